// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the update session checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define FUSC_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`define FUSC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FUSC_ASSERT(name, clk, rst_n, prop, msg)
`define FUSC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/fusc_pkg.sv -----
// ---------------------------------------------------------------------------
// Update session checker package
// Command and error codes, register layout and the records passed between
// the front end, the queue and the back end.
// ---------------------------------------------------------------------------
package fusc_pkg;

    typedef enum logic [2:0] {
        FUNC_HANDSHAKE = 3'd0,
        FUNC_HEADER    = 3'd1,
        FUNC_DATA      = 3'd2,
        FUNC_COMPLETE  = 3'd3,
        FUNC_INSTALL   = 3'd4,
        FUNC_ACTIVATE  = 3'd5,
        FUNC_QUERY     = 3'd6,
        FUNC_OTHER     = 3'd7
    } t_func;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_SEQUENCE = 3'd1,
        ERR_SPACE    = 3'd2,
        ERR_VERIFY   = 3'd3,
        ERR_BUSY     = 3'd4
    } t_err;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HS_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLK_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CMP_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MTU        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_FREE = 3'd5;

    typedef struct packed {
        logic [7:0]  hs_min;
        logic [7:0]  blk_min;
        logic [7:0]  cmp_min;
        logic [15:0] max_packet;
        logic [15:0] mtu;
        logic [31:0] flash_free;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        hs_min:     8'd20,
        blk_min:    8'd8,
        cmp_min:    8'd4,
        max_packet: 16'd256,
        mtu:        16'd512,
        flash_free: 32'(256 * 1024)
    };

    typedef struct packed {
        logic [7:0] major;
        logic [7:0] minor;
        logic [7:0] patch;
    } t_version;

    localparam t_version VER_RESET = '{major: 8'd1, minor: 8'd0, patch: 8'd0};

    typedef struct packed {
        t_func       func;
        t_version    ver;
        logic [31:0] image_size;
        logic [15:0] blk_timeout;
        logic [15:0] inst_timeout;
        logic [31:0] block_offset;
        logic [15:0] block_length;
        logic        len_short;
        logic [32:0] block_end;
        logic [31:0] claimed_size;
    } t_cmd;

    typedef struct packed {
        t_func       kind;
        t_err        err;
        logic [31:0] offset;
        logic [15:0] max_packet;
        logic [15:0] mtu;
        logic [31:0] flash_free;
        logic [15:0] blk_timeout;
        logic [15:0] inst_timeout;
        logic        est_time;
        t_version    cur;
    } t_resp;

endpackage

// ----- rtl/firmware_update_session_checker.sv -----
// ---------------------------------------------------------------------------
// Firmware update session checker
// Checks decoded update command frames against the session state and gives
// one response beat for each frame that is long enough and known.
//
//   Channel   Handshake                     Payload
//   input     i_in_valid / o_in_stall       i_func .. i_claimed_size
//   output    o_out_valid / i_out_stall     o_resp_kind .. o_cur_patch
//   config    i_cfg_we                      i_cfg_index, i_cfg_wdata
//
// One beat is taken per cycle unless the queue is full; its response is registered.
// The front end classifies in the accept cycle and the back end executes one
// queued command per cycle into the output register unless the output stalls.
// Synchronous active low reset; no clearing pass, the block is ready at once.
// A stalled output holds its response while the queue of QUEUE_DEPTH beats
// fills; the input stalls only when that queue is full.
// ---------------------------------------------------------------------------
module firmware_update_session_checker #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fusc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fusc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [2:0]                      i_func,
    input  logic [15:0]                     i_frame_length,
    input  logic [7:0]                      i_ver_major,
    input  logic [7:0]                      i_ver_minor,
    input  logic [7:0]                      i_ver_patch,
    input  logic [31:0]                     i_image_size,
    input  logic [15:0]                     i_blk_timeout,
    input  logic [15:0]                     i_inst_timeout,
    input  logic [31:0]                     i_block_offset,
    input  logic [15:0]                     i_block_length,
    input  logic [31:0]                     i_claimed_size,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_resp_kind,
    output logic [2:0]                      o_err_code,
    output logic [31:0]                     o_offset_out,
    output logic [15:0]                     o_max_packet_out,
    output logic [15:0]                     o_mtu_out,
    output logic [31:0]                     o_flash_free_out,
    output logic [15:0]                     o_blk_timeout_out,
    output logic [15:0]                     o_inst_timeout_out,
    output logic                            o_est_time,
    output logic [7:0]                      o_cur_major,
    output logic [7:0]                      o_cur_minor,
    output logic [7:0]                      o_cur_patch
);

    fusc_pkg::t_cfg  r_cfg;
    fusc_pkg::t_cmd  front_cmd;
    fusc_pkg::t_cmd  queue_cmd;
    fusc_pkg::t_resp resp;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= fusc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fusc_pkg::CFG_HS_MIN:     r_cfg.hs_min     <= i_cfg_wdata[7:0];
                fusc_pkg::CFG_BLK_MIN:    r_cfg.blk_min    <= i_cfg_wdata[7:0];
                fusc_pkg::CFG_CMP_MIN:    r_cfg.cmp_min    <= i_cfg_wdata[7:0];
                fusc_pkg::CFG_MAX_PACKET: r_cfg.max_packet <= i_cfg_wdata[15:0];
                fusc_pkg::CFG_MTU:        r_cfg.mtu        <= i_cfg_wdata[15:0];
                fusc_pkg::CFG_FLASH_FREE: r_cfg.flash_free <= i_cfg_wdata[31:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    fusc_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_frame_length (i_frame_length),
        .i_ver_major    (i_ver_major),
        .i_ver_minor    (i_ver_minor),
        .i_ver_patch    (i_ver_patch),
        .i_image_size   (i_image_size),
        .i_blk_timeout  (i_blk_timeout),
        .i_inst_timeout (i_inst_timeout),
        .i_block_offset (i_block_offset),
        .i_block_length (i_block_length),
        .i_claimed_size (i_claimed_size),
        .i_cfg          (r_cfg),
        .i_queue_full   (queue_full),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    fusc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    fusc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (queue_valid),
        .i_cmd       (queue_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_resp      (resp)
    );

    assign o_resp_kind        = resp.kind;
    assign o_err_code         = resp.err;
    assign o_offset_out       = resp.offset;
    assign o_max_packet_out   = resp.max_packet;
    assign o_mtu_out          = resp.mtu;
    assign o_flash_free_out   = resp.flash_free;
    assign o_blk_timeout_out  = resp.blk_timeout;
    assign o_inst_timeout_out = resp.inst_timeout;
    assign o_est_time         = resp.est_time;
    assign o_cur_major        = resp.cur.major;
    assign o_cur_minor        = resp.cur.minor;
    assign o_cur_patch        = resp.cur.patch;

endmodule

// ----- rtl/fusc_front.sv -----
// ---------------------------------------------------------------------------
// Update session checker front end
// Takes command beats, drops short and unknown frames and precomputes the
// session independent parts of the data block checks.
// ---------------------------------------------------------------------------
module fusc_front (
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [2:0]           i_func,
    input  logic [15:0]          i_frame_length,
    input  logic [7:0]           i_ver_major,
    input  logic [7:0]           i_ver_minor,
    input  logic [7:0]           i_ver_patch,
    input  logic [31:0]          i_image_size,
    input  logic [15:0]          i_blk_timeout,
    input  logic [15:0]          i_inst_timeout,
    input  logic [31:0]          i_block_offset,
    input  logic [15:0]          i_block_length,
    input  logic [31:0]          i_claimed_size,
    input  fusc_pkg::t_cfg       i_cfg,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output fusc_pkg::t_cmd       o_cmd
);

    fusc_pkg::t_func func;
    logic            keep;
    logic [16:0]     len_need;

    assign func     = fusc_pkg::t_func'(i_func);
    assign len_need = 17'(i_cfg.blk_min) + 17'(i_block_length);

    always_comb begin
        unique case (func)
            fusc_pkg::FUNC_HANDSHAKE: begin
                keep = i_frame_length >= 16'(i_cfg.hs_min);
            end
            fusc_pkg::FUNC_DATA: begin
                keep = i_frame_length >= 16'(i_cfg.blk_min);
            end
            fusc_pkg::FUNC_COMPLETE: begin
                keep = i_frame_length >= 16'(i_cfg.cmp_min);
            end
            fusc_pkg::FUNC_OTHER: begin
                keep = 1'b0;
            end
            default: begin
                keep = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_cmd.func         = func;
        o_cmd.ver.major    = i_ver_major;
        o_cmd.ver.minor    = i_ver_minor;
        o_cmd.ver.patch    = i_ver_patch;
        o_cmd.image_size   = i_image_size;
        o_cmd.blk_timeout  = i_blk_timeout;
        o_cmd.inst_timeout = i_inst_timeout;
        o_cmd.block_offset = i_block_offset;
        o_cmd.block_length = i_block_length;
        o_cmd.len_short    = {1'b0, i_frame_length} < len_need;
        o_cmd.block_end    = 33'(i_block_offset) + 33'(i_block_length);
        o_cmd.claimed_size = i_claimed_size;
    end

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full && keep;

endmodule

// ----- rtl/fusc_queue.sv -----
// ---------------------------------------------------------------------------
// Update session checker command queue
// Small first-in first-out buffer between the front end and the back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fusc_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fusc_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output fusc_pkg::t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    fusc_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_cmd   = r_mem[r_rd];
    assign o_valid = r_count != '0;
    assign o_full  = r_count == CNT_W'(DEPTH);

    `FUSC_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push into a full queue")
    `FUSC_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && !o_valid), "pop from an empty queue")
    `FUSC_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue count lost a push")

endmodule

// ----- rtl/fusc_back.sv -----
// ---------------------------------------------------------------------------
// Update session checker back end
// Holds the session state, executes one queued command per cycle unless the
// output is stalled and keeps the response in an output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fusc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fusc_pkg::t_cfg     i_cfg,
    input  logic               i_q_valid,
    input  fusc_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fusc_pkg::t_resp    o_resp
);

    fusc_pkg::t_version r_cur;
    fusc_pkg::t_version r_tgt;
    logic [31:0]        r_ann;
    logic [31:0]        r_rcv;
    logic               r_hs;
    logic               r_hdr;
    logic               r_done;
    logic               r_out_valid;
    fusc_pkg::t_resp    r_resp;

    fusc_pkg::t_version n_cur;
    fusc_pkg::t_version n_tgt;
    logic [31:0]        n_ann;
    logic [31:0]        n_rcv;
    logic               n_hs;
    logic               n_hdr;
    logic               n_done;
    fusc_pkg::t_resp    n_resp;
    logic               open;

    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);
    assign open  = r_hs && r_hdr;

    always_comb begin
        n_cur       = r_cur;
        n_tgt       = r_tgt;
        n_ann       = r_ann;
        n_rcv       = r_rcv;
        n_hs        = r_hs;
        n_hdr       = r_hdr;
        n_done      = r_done;
        n_resp      = '0;
        n_resp.kind = i_cmd.func;
        n_resp.err  = fusc_pkg::ERR_OK;
        unique case (i_cmd.func)
            fusc_pkg::FUNC_HANDSHAKE: begin
                n_tgt               = i_cmd.ver;
                n_ann               = i_cmd.image_size;
                n_rcv               = '0;
                n_hs                = 1'b1;
                n_hdr               = 1'b0;
                n_done              = 1'b0;
                n_resp.max_packet   = i_cfg.max_packet;
                n_resp.mtu          = i_cfg.mtu;
                n_resp.flash_free   = i_cfg.flash_free;
                n_resp.blk_timeout  = i_cmd.blk_timeout;
                n_resp.inst_timeout = i_cmd.inst_timeout;
            end
            fusc_pkg::FUNC_HEADER: begin
                if (!r_hs) begin
                    n_resp.err = fusc_pkg::ERR_SEQUENCE;
                end else begin
                    n_hdr  = 1'b1;
                    n_done = 1'b0;
                end
            end
            fusc_pkg::FUNC_DATA: begin
                if (!open || i_cmd.len_short || i_cmd.block_offset != r_rcv) begin
                    n_resp.err = fusc_pkg::ERR_SEQUENCE;
                end else if (i_cmd.block_end > {1'b0, r_ann}) begin
                    n_resp.err = fusc_pkg::ERR_SPACE;
                end else begin
                    n_rcv = r_rcv + 32'(i_cmd.block_length);
                end
                n_resp.offset = n_rcv;
            end
            fusc_pkg::FUNC_COMPLETE: begin
                if (!open || i_cmd.claimed_size != r_ann || r_rcv != r_ann) begin
                    n_resp.err = fusc_pkg::ERR_VERIFY;
                end else begin
                    n_done = 1'b1;
                end
            end
            fusc_pkg::FUNC_INSTALL: begin
                if (!r_done) begin
                    n_resp.err = fusc_pkg::ERR_BUSY;
                end else begin
                    n_resp.est_time = 1'b1;
                    n_cur           = r_tgt;
                end
            end
            fusc_pkg::FUNC_ACTIVATE, fusc_pkg::FUNC_QUERY: begin
                n_resp.cur = r_cur;
            end
            default: begin
                n_resp.kind = i_cmd.func;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= fusc_pkg::VER_RESET;
            r_tgt       <= fusc_pkg::VER_RESET;
            r_ann       <= '0;
            r_rcv       <= '0;
            r_hs        <= 1'b0;
            r_hdr       <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur  <= n_cur;
                r_tgt  <= n_tgt;
                r_ann  <= n_ann;
                r_rcv  <= n_rcv;
                r_hs   <= n_hs;
                r_hdr  <= n_hdr;
                r_done <= n_done;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_resp <= n_resp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_resp      = r_resp;

    `FUSC_ASSERT(a_count_in_size, i_clk, i_rst_n, r_rcv <= r_ann, "received count beyond announced size")
    `FUSC_ASSERT(a_session_order, i_clk, i_rst_n, (!r_hdr || r_hs) && (!r_done || open), "session flags out of order")
    `FUSC_ASSERT_NEXT(a_install_copies, i_clk, i_rst_n, o_pop && i_cmd.func == fusc_pkg::FUNC_INSTALL && r_done, r_cur == $past(r_tgt) && o_out_valid && o_resp.est_time, "install did not take the target version")

endmodule
